>>> src/ascii_graymap_parser_unit_defines.svh
// Assertion macros for the graymap parser RTL.
`ifndef ASCII_GRAYMAP_PARSER_UNIT_DEFINES_SVH
`define ASCII_GRAYMAP_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define AGP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AGP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define AGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/agp_pkg.sv
package agp_pkg;

    // Width of every numeric result field.
    localparam int FIELD_BITS = 16;
    localparam int VALUE_BITS_DEFAULT = 16;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Parse phase.
    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_COMMENT    = 3'd1,
        PH_SEEN_P     = 3'd2,
        PH_MAGIC_REST = 3'd3,
        PH_BODY       = 3'd4,
        PH_HALT       = 3'd5
    } phase_t;

    // Result kind.
    typedef enum logic [2:0] {
        K_WIDTH  = 3'd0,
        K_HEIGHT = 3'd1,
        K_MAXVAL = 3'd2,
        K_PIXEL  = 3'd3,
        K_EXTRA  = 3'd4,
        K_ERROR  = 3'd5,
        K_END    = 3'd6
    } kind_t;

    // Complete parser state.
    typedef struct packed {
        phase_t                phase;
        logic                  skip_line;
        logic                  in_number;
        logic [FIELD_BITS-1:0] accum;
        logic [1:0]            header_count;
        logic [FIELD_BITS-1:0] img_width;
        logic [FIELD_BITS-1:0] img_height;
        logic [FIELD_BITS-1:0] cur_row;
        logic [FIELD_BITS-1:0] cur_col;
        logic [FIELD_BITS-1:0] max_seen;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_LINE_START,
        skip_line:    1'b0,
        in_number:    1'b0,
        accum:        '0,
        header_count: 2'd0,
        img_width:    '0,
        img_height:   '0,
        cur_row:      '0,
        cur_col:      '0,
        max_seen:     '0
    };

    // One result item.
    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] value;
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] col;
        logic [FIELD_BITS-1:0] running_max;
        logic                  done_res;
    } result_t;

endpackage

>>> src/agp_step.sv
module agp_step #(
    parameter int VALUE_BITS = agp_pkg::VALUE_BITS_DEFAULT
) (
    input  agp_pkg::parse_state_t state_cur,
    input  logic [7:0]            ch,
    input  logic                  end_of_file,
    output agp_pkg::parse_state_t state_nxt,
    output logic                  res_valid,
    output agp_pkg::result_t      res
);

    localparam int FB = agp_pkg::FIELD_BITS;
    localparam int LIMIT_BITS = (VALUE_BITS < FB) ? VALUE_BITS : FB;
    localparam logic [FB-1:0] VALUE_LIMIT = FB'((64'd1 << LIMIT_BITS) - 64'd1);

    logic            is_digit;
    logic            is_space;
    logic [FB+3:0]   accum_mul;
    logic [FB:0]     col_inc;
    agp_pkg::phase_t phase_nxt;

    // Character classes and the decimal accumulate step.
    assign is_digit = (ch >= agp_pkg::CH_ZERO) && (ch <= agp_pkg::CH_NINE);
    assign is_space = (ch == agp_pkg::CH_SPACE) || (ch == agp_pkg::CH_TAB)
                    || (ch == agp_pkg::CH_NEWLINE);
    assign accum_mul = ({4'd0, state_cur.accum} << 3) + ({4'd0, state_cur.accum} << 1)
                     + {{(FB+4-8){1'b0}}, ch - agp_pkg::CH_ZERO};
    assign col_inc = {1'b0, state_cur.cur_col} + {{FB{1'b0}}, 1'b1};

    // Next phase.
    always_comb
    begin
        phase_nxt = state_cur.phase;
        case (state_cur.phase)
            agp_pkg::PH_LINE_START:
            begin
                if (end_of_file)
                    phase_nxt = agp_pkg::PH_HALT;
                else if (ch == agp_pkg::CH_HASH)
                    phase_nxt = agp_pkg::PH_COMMENT;
                else if (ch == agp_pkg::CH_P)
                    phase_nxt = agp_pkg::PH_SEEN_P;
                else
                    phase_nxt = agp_pkg::PH_HALT;
            end
            agp_pkg::PH_COMMENT:
            begin
                if (end_of_file)
                    phase_nxt = agp_pkg::PH_HALT;
                else if (ch == agp_pkg::CH_NEWLINE)
                    phase_nxt = agp_pkg::PH_LINE_START;
            end
            agp_pkg::PH_SEEN_P:
            begin
                if (!end_of_file && ch == agp_pkg::CH_TWO)
                    phase_nxt = agp_pkg::PH_MAGIC_REST;
                else
                    phase_nxt = agp_pkg::PH_HALT;
            end
            agp_pkg::PH_MAGIC_REST:
            begin
                if (end_of_file)
                    phase_nxt = agp_pkg::PH_HALT;
                else if (ch == agp_pkg::CH_NEWLINE)
                    phase_nxt = agp_pkg::PH_BODY;
            end
            agp_pkg::PH_BODY:
            begin
                if (end_of_file)
                    phase_nxt = agp_pkg::PH_HALT;
            end
            agp_pkg::PH_HALT:
            begin
                phase_nxt = agp_pkg::PH_HALT;
            end
            default:
            begin
                phase_nxt = agp_pkg::PH_HALT;
            end
        endcase
    end

    // Datapath and result for the current item.
    always_comb
    begin
        state_nxt       = state_cur;
        state_nxt.phase = phase_nxt;
        res_valid       = 1'b0;
        res             = '0;
        res.kind        = agp_pkg::K_END;

        case (state_cur.phase)
            agp_pkg::PH_LINE_START, agp_pkg::PH_COMMENT, agp_pkg::PH_MAGIC_REST:
            begin
                if (end_of_file)
                begin
                    res_valid       = 1'b1;
                    res.kind        = agp_pkg::K_END;
                    res.running_max = state_cur.max_seen;
                    res.done_res    = 1'b1;
                end
                else if (state_cur.phase == agp_pkg::PH_LINE_START
                         && ch != agp_pkg::CH_HASH && ch != agp_pkg::CH_P)
                begin
                    res_valid    = 1'b1;
                    res.kind     = agp_pkg::K_ERROR;
                    res.done_res = 1'b1;
                end
            end
            agp_pkg::PH_SEEN_P:
            begin
                if (end_of_file || ch != agp_pkg::CH_TWO)
                begin
                    res_valid    = 1'b1;
                    res.kind     = agp_pkg::K_ERROR;
                    res.done_res = 1'b1;
                end
            end
            agp_pkg::PH_BODY:
            begin
                if (state_cur.in_number && (end_of_file || (!state_cur.skip_line
                    && (ch == agp_pkg::CH_HASH || is_space))))
                begin
                    // A pending number ends here and is reported.
                    res_valid           = 1'b1;
                    res.value           = state_cur.accum;
                    res.running_max     = state_cur.max_seen;
                    res.done_res        = end_of_file;
                    state_nxt.in_number = 1'b0;
                    state_nxt.accum     = '0;
                    if (state_cur.header_count != 2'd3)
                    begin
                        res.kind               = agp_pkg::kind_t'(state_cur.header_count);
                        state_nxt.header_count = state_cur.header_count + 2'd1;
                        if (state_cur.header_count == 2'd0)
                            state_nxt.img_width = state_cur.accum;
                        if (state_cur.header_count == 2'd1)
                            state_nxt.img_height = state_cur.accum;
                    end
                    else if (state_cur.cur_row >= state_cur.img_height)
                    begin
                        res.kind = agp_pkg::K_EXTRA;
                    end
                    else
                    begin
                        res.kind = agp_pkg::K_PIXEL;
                        res.row  = state_cur.cur_row;
                        res.col  = state_cur.cur_col;
                        if (state_cur.accum > state_cur.max_seen)
                        begin
                            state_nxt.max_seen = state_cur.accum;
                            res.running_max    = state_cur.accum;
                        end
                        if (col_inc >= {1'b0, state_cur.img_width})
                        begin
                            state_nxt.cur_col = '0;
                            state_nxt.cur_row = state_cur.cur_row + {{(FB-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            state_nxt.cur_col = col_inc[FB-1:0];
                        end
                    end
                end
                else if (end_of_file)
                begin
                    res_valid       = 1'b1;
                    res.kind        = agp_pkg::K_END;
                    res.running_max = state_cur.max_seen;
                    res.done_res    = 1'b1;
                end

                // Comment skipping and digit accumulation.
                if (!end_of_file)
                begin
                    if (state_cur.skip_line)
                    begin
                        if (ch == agp_pkg::CH_NEWLINE)
                            state_nxt.skip_line = 1'b0;
                    end
                    else if (ch == agp_pkg::CH_HASH)
                    begin
                        state_nxt.skip_line = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        state_nxt.in_number = 1'b1;
                        if (accum_mul > {4'd0, VALUE_LIMIT})
                            state_nxt.accum = VALUE_LIMIT;
                        else
                            state_nxt.accum = accum_mul[FB-1:0];
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

>>> src/ascii_graymap_parser_unit.sv
// Channel   Dir  tdata                               tuser      tlast
// s_axis    in   [7:0] ch                            -          end_of_file
// m_axis    out  [15:0] value, [31:16] row,          [2:0] kind done_res
//                [47:32] col, [63:48] running_max
//
// One byte item is taken per clock while the output is not stalled. An accepted
// item waits in the input register; its result is then held in the result
// register, from which it is presented and taken.
// The parse step between the two registers is a single short pass.
// Reset returns the parser to the start of the header and empties both
// registers. A stalled output holds its result and stops the input register
// only when both are full.
`include "ascii_graymap_parser_unit_defines.svh"

module ascii_graymap_parser_unit #(
    parameter int VALUE_BITS = agp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // value, row, col, running_max
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            ch_reg;
    logic                  eof_reg;
    agp_pkg::parse_state_t state_reg;
    agp_pkg::parse_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    agp_pkg::result_t      out_res_reg;
    agp_pkg::result_t      step_res;
    logic                  step_valid;
    logic                  advance;
    logic                  in_take;

    // Handshake: the held item moves on when the result register is empty or its result is being taken.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // One parse step per item.
    agp_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .state_cur  (state_reg),
        .ch         (ch_reg),
        .end_of_file(eof_reg),
        .state_nxt  (state_next),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    // Valid flags for both registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = step_valid;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control and parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= agp_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg  <= s_axis_tdata;
            eof_reg <= s_axis_tlast;
        end
        if (advance && step_valid)
            out_res_reg <= step_res;
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.running_max, out_res_reg.col,
                            out_res_reg.row, out_res_reg.value};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.done_res;

    // Checks.
    `AGP_ASSERT_SAME(a_done_halts, clk, rst_n,
        out_valid_reg && out_res_reg.done_res,
        state_reg.phase == agp_pkg::PH_HALT, "final result without halted parser")
    `AGP_ASSERT_NEXT(a_nothing_after_done, clk, rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast,
        !m_axis_tvalid, "result after the final result")
    `AGP_ASSERT_SAME(a_pixel_max, clk, rst_n,
        out_valid_reg && out_res_reg.kind == agp_pkg::K_PIXEL,
        out_res_reg.running_max >= out_res_reg.value, "running maximum below pixel")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import agp_pkg::*;

    // Largest number the parser keeps before it saturates.
    localparam int NUMBER_LIMIT = (VALUE_BITS_DEFAULT >= FIELD_BITS) ?
                                  65535 : (1 << VALUE_BITS_DEFAULT) - 1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] ch
    logic        s_axis_tlast;   // end_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [15:0] value, [31:16] row, [47:32] col, [63:48] running_max
    logic [2:0]  m_axis_tuser;   // [2:0] kind
    logic        m_axis_tlast;   // done_res

    // Shadow copy of the parser state, advanced on every accepted byte.
    phase_t                gm_phase;
    logic                  gm_skip_line;
    logic                  gm_in_number;
    logic [FIELD_BITS-1:0] gm_accum;
    logic [1:0]            gm_header_count;
    logic [FIELD_BITS-1:0] gm_width;
    logic [FIELD_BITS-1:0] gm_height;
    logic [FIELD_BITS-1:0] gm_row;
    logic [FIELD_BITS-1:0] gm_col;
    logic [FIELD_BITS-1:0] gm_max;

    // Results the parser still owes, oldest first.
    result_t parsed_results[$];

    int  fail_count = 0;
    int  bytes_accepted = 0;
    int  results_checked = 0;
    int  pixel_count = 0;
    int  extra_count = 0;
    bit  src_idle = 1'b0;
    bit  sink_idle = 1'b0;
    int  long_hold_cycles = 0;

    ascii_graymap_parser_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue one expected result.
    task automatic push_result(input kind_t kind, input logic [15:0] value,
                               input logic [15:0] row, input logic [15:0] col,
                               input logic [15:0] rmax, input logic done);
        result_t res;
        res.kind        = kind;
        res.value       = value;
        res.row         = row;
        res.col         = col;
        res.running_max = rmax;
        res.done_res    = done;
        parsed_results.push_back(res);
    endtask

    // Report the pending number as a header field, a pixel or an extra value.
    task automatic finish_number(input logic done);
        logic [FIELD_BITS-1:0] num;
        num = gm_accum;
        gm_in_number = 1'b0;
        gm_accum = '0;
        if (gm_header_count < 2'd3)
        begin
            if (gm_header_count == 2'd0)
                gm_width = num;
            else if (gm_header_count == 2'd1)
                gm_height = num;
            push_result(kind_t'(gm_header_count), num, '0, '0, gm_max, done);
            gm_header_count = gm_header_count + 2'd1;
        end
        else if (gm_row >= gm_height)
        begin
            push_result(K_EXTRA, num, '0, '0, gm_max, done);
        end
        else
        begin
            if (num > gm_max)
                gm_max = num;
            push_result(K_PIXEL, num, gm_row, gm_col, gm_max, done);
            gm_col = gm_col + 16'd1;
            if (gm_col >= gm_width)
            begin
                gm_col = '0;
                gm_row = gm_row + 16'd1;
            end
        end
    endtask

    // Advance the shadow parser by one accepted byte.
    task automatic parse_byte(input logic [7:0] ch, input logic eof);
        int next_val;
        if (gm_phase == PH_HALT)
            return;
        if (gm_phase != PH_BODY)
        begin
            // Header: comment lines, then the magic line.
            if (eof)
            begin
                if (gm_phase == PH_SEEN_P)
                    push_result(K_ERROR, '0, '0, '0, '0, 1'b1);
                else
                    push_result(K_END, '0, '0, '0, gm_max, 1'b1);
                gm_phase = PH_HALT;
                return;
            end
            case (gm_phase)
                PH_LINE_START:
                begin
                    if (ch == CH_HASH)
                        gm_phase = PH_COMMENT;
                    else if (ch == CH_P)
                        gm_phase = PH_SEEN_P;
                    else
                    begin
                        push_result(K_ERROR, '0, '0, '0, '0, 1'b1);
                        gm_phase = PH_HALT;
                    end
                end
                PH_COMMENT:
                begin
                    if (ch == CH_NEWLINE)
                        gm_phase = PH_LINE_START;
                end
                PH_SEEN_P:
                begin
                    if (ch == CH_TWO)
                        gm_phase = PH_MAGIC_REST;
                    else
                    begin
                        push_result(K_ERROR, '0, '0, '0, '0, 1'b1);
                        gm_phase = PH_HALT;
                    end
                end
                default:
                begin
                    if (ch == CH_NEWLINE)
                        gm_phase = PH_BODY;
                end
            endcase
            return;
        end
        // Body: numbers, separators and comments.
        if (eof)
        begin
            gm_phase = PH_HALT;
            if (gm_in_number)
                finish_number(1'b1);
            else
                push_result(K_END, '0, '0, '0, gm_max, 1'b1);
        end
        else if (gm_skip_line)
        begin
            if (ch == CH_NEWLINE)
                gm_skip_line = 1'b0;
        end
        else if (ch == CH_HASH)
        begin
            gm_skip_line = 1'b1;
            if (gm_in_number)
                finish_number(1'b0);
        end
        else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE)
        begin
            if (gm_in_number)
                finish_number(1'b0);
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            next_val = int'(gm_accum) * 10 + int'(ch - CH_ZERO);
            gm_accum = (next_val > NUMBER_LIMIT) ? FIELD_BITS'(NUMBER_LIMIT)
                                                 : FIELD_BITS'(next_val);
            gm_in_number = 1'b1;
        end
    endtask

    // Offer one byte, wait for the handshake, then update the prediction.
    // Called and returns just after a falling edge.
    task automatic send_byte(input logic [7:0] ch, input logic eof);
        int gap;
        if (src_idle && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_accepted++;
        parse_byte(ch, eof);
        @(negedge clk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], 1'b0);
    endtask

    // A random number with a random separator, or a stray byte.
    task automatic send_random_token();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        if ($urandom_range(0, 11) == 0)
            send_text($sformatf("%0d", $urandom_range(65530, 999999)));
        else
            send_text($sformatf("%0d", $urandom_range(0, 999)));
        case ($urandom_range(0, 4))
            0, 1:    send_byte(CH_SPACE, 1'b0);
            2:       send_byte(CH_TAB, 1'b0);
            3:       send_byte(CH_NEWLINE, 1'b0);
            default:
            begin
                send_byte(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 5))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(CH_NEWLINE, 1'b0);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare every accepted result with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (parsed_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d",
                       m_axis_tuser, m_axis_tdata[15:0]);
                fail_count++;
            end
            else
            begin
                want = parsed_results.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("value", want.value, m_axis_tdata[15:0]);
                check_field("row", want.row, m_axis_tdata[31:16]);
                check_field("col", want.col, m_axis_tdata[47:32]);
                check_field("running_max", want.running_max, m_axis_tdata[63:48]);
                check_field("done_res", want.done_res, m_axis_tlast);
                if (want.kind == K_PIXEL)
                    pixel_count++;
                if (want.kind == K_EXTRA)
                    extra_count++;
            end
            results_checked++;
        end
    end

    // Result receiver: random stall bursts, plus one long hold on request.
    initial
    begin : result_sink
        int hold;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles != 0)
            begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            else if (sink_idle && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Comment line, magic line, header with saturated maxval, and the
    // number corner cases: hash right after a digit, stray bytes inside a
    // number, and zero.
    task automatic test_header_and_specials();
        int width;
        int height;
        width  = $urandom_range(0, 8);
        height = $urandom_range(1, 12);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_text("#c\n");
        send_text("P2 x\n");
        send_text($sformatf("%0d\t%0d\n", width, height));
        send_text("99999 ");
        send_text("12#q\n");
        send_byte(CH_ZERO + 8'd3, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("4\n");
        send_text("0 ");
    endtask

    // Random body text, with idling switched on and off in stretches.
    task automatic test_random_body();
        int start_count;
        int stretch_start;
        start_count   = bytes_accepted;
        stretch_start = bytes_accepted;
        while (bytes_accepted - start_count < 600)
        begin
            if (bytes_accepted - stretch_start >= 100)
            begin
                stretch_start = bytes_accepted;
                src_idle  = ($urandom_range(0, 2) != 0);
                sink_idle = ($urandom_range(0, 2) != 0);
            end
            send_random_token();
        end
    endtask

    // Hold the receiver for a long stretch while short numbers keep coming,
    // then let the sender sit until every result is out. A newline first
    // closes any comment left open by a stray hash byte.
    task automatic test_output_stall();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_byte(CH_NEWLINE, 1'b0);
        long_hold_cycles = 80;
        repeat (30)
            send_text("5 ");
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (parsed_results.size() != 0)
            @(negedge clk);
    endtask

    // No idling: a few more tokens, a number ended by end of file, then
    // bytes that the halted parser must ignore.
    task automatic test_end_of_file();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (15)
            send_random_token();
        send_byte(CH_NEWLINE, 1'b0);
        send_text("417");
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (3)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        gm_phase        = PH_LINE_START;
        gm_skip_line    = 1'b0;
        gm_in_number    = 1'b0;
        gm_accum        = '0;
        gm_header_count = 2'd0;
        gm_width        = '0;
        gm_height       = '0;
        gm_row          = '0;
        gm_col          = '0;
        gm_max          = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_header_and_specials();
        test_random_body();
        test_output_stall();
        test_end_of_file();

        // Drain, then allow for the two-stage pipeline.
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Parsed %0d bytes into %0d results, %0d pixels and %0d extra values",
                 bytes_accepted, results_checked, pixel_count, extra_count);
        $display("Image header %0d x %0d, largest pixel %0d", gm_width, gm_height, gm_max);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
